// ===== rtl/core/heat_stencil_cell_with_colormap_top_defines.svh =====
// Assertion macros for the top-level file, which checks its own logic.
`ifndef HEAT_STENCIL_CELL_WITH_COLORMAP_TOP_DEFINES_SVH
`define HEAT_STENCIL_CELL_WITH_COLORMAP_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define HSCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define HSCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hscc_pkg.sv =====
package hscc_pkg;

    localparam int TEMP_W    = 16;
    localparam int COEFF_W   = 16;
    localparam int PEAK_W    = 15;
    localparam int INV_W     = 28;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_X   = 2'd0,
        REG_COEFF_Y   = 2'd1,
        REG_PEAK_TEMP = 2'd2,
        REG_INV_PEAK  = 2'd3
    } cfg_reg_e;

    localparam logic [COEFF_W-1:0] COEFF_X_RST   = 16'd6554;
    localparam logic [COEFF_W-1:0] COEFF_Y_RST   = 16'd6554;
    localparam logic [PEAK_W-1:0]  PEAK_TEMP_RST = 15'd3200;
    localparam logic [INV_W-1:0]   INV_PEAK_RST  = 28'd83886;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

    typedef struct packed {
        logic signed [TEMP_W-1:0] centre;
        logic signed [TEMP_W-1:0] north;
        logic signed [TEMP_W-1:0] south;
        logic signed [TEMP_W-1:0] east;
        logic signed [TEMP_W-1:0] west;
        logic                     source_present;
        logic signed [TEMP_W-1:0] source_value;
        logic                     on_border;
    } cell_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] new_temp;
        logic [COLOR_W-1:0]       red;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       blue;
    } pix_t;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff_x;
        logic [COEFF_W-1:0] coeff_y;
        logic [PEAK_W-1:0]  peak_temp;
        logic [INV_W-1:0]   inv_peak;
    } cfg_t;

endpackage

// ===== rtl/core/hscc_ifs.sv =====
interface hscc_cell_if import hscc_pkg::*; ();
    logic  valid;
    logic  ready;
    cell_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hscc_pix_if import hscc_pkg::*; ();
    logic valid;
    logic ready;
    pix_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hscc_cfg_if import hscc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/hscc_cfg_regs.sv =====
module hscc_cfg_regs import hscc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    hscc_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                REG_COEFF_X:   regs_next.coeff_x   = cfg.wdata[COEFF_W-1:0];
                REG_COEFF_Y:   regs_next.coeff_y   = cfg.wdata[COEFF_W-1:0];
                REG_PEAK_TEMP: regs_next.peak_temp = cfg.wdata[PEAK_W-1:0];
                REG_INV_PEAK:  regs_next.inv_peak  = cfg.wdata[INV_W-1:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.coeff_x   <= COEFF_X_RST;
            regs_reg.coeff_y   <= COEFF_Y_RST;
            regs_reg.peak_temp <= PEAK_TEMP_RST;
            regs_reg.inv_peak  <= INV_PEAK_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== rtl/core/hscc_stencil.sv =====
module hscc_stencil import hscc_pkg::*; (
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [TEMP_W-1:0] centre,
    input  logic signed [TEMP_W-1:0] north,
    input  logic signed [TEMP_W-1:0] south,
    input  logic signed [TEMP_W-1:0] east,
    input  logic signed [TEMP_W-1:0] west,
    input  logic                     on_border,
    input  logic [COEFF_W-1:0]       coeff_x,
    input  logic [COEFF_W-1:0]       coeff_y,
    output logic signed [TEMP_W-1:0] new_temp
);

    localparam int DIFF_W = TEMP_W + 2;
    localparam int PROD_W = COEFF_W + 1 + DIFF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int DLT_W  = ACC_W - 16;
    localparam int SUM_W  = DLT_W + 1;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] c2;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [TEMP_W-1:0] centre_reg;
    logic                     border_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DLT_W-1:0]  delta;
    logic signed [SUM_W-1:0]  sum;

    always_comb
    begin
        c2 = DIFF_W'(centre) <<< 1;
        dx = DIFF_W'(east) + DIFF_W'(west) - c2;
        dy = DIFF_W'(north) + DIFF_W'(south) - c2;
        px_next = $signed({1'b0, coeff_x}) * dx;
        py_next = $signed({1'b0, coeff_y}) * dy;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            centre_reg <= centre;
            border_reg <= on_border;
        end
    end

    // Round to nearest with ties up, then saturate the updated temperature; a border cell keeps its centre value.
    always_comb
    begin
        acc   = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(32768);
        delta = acc[ACC_W-1:16];
        sum   = SUM_W'(centre_reg) + SUM_W'(delta);
        if (border_reg)
        begin
            new_temp = centre_reg;
        end
        else if (sum > SUM_W'(32767))
        begin
            new_temp = 16'sh7FFF;
        end
        else if (sum < -SUM_W'(32768))
        begin
            new_temp = -16'sh8000;
        end
        else
        begin
            new_temp = sum[TEMP_W-1:0];
        end
    end

endmodule

// ===== rtl/core/hscc_colormap.sv =====
module hscc_colormap import hscc_pkg::*; (
    input  logic                     clk,
    input  logic                     load,
    input  logic signed [TEMP_W-1:0] temp,
    input  logic [PEAK_W-1:0]        peak_temp,
    input  logic [INV_W-1:0]         inv_peak,
    output logic [COLOR_W-1:0]       red,
    output logic [COLOR_W-1:0]       green,
    output logic [COLOR_W-1:0]       blue
);

    localparam int F_W = PEAK_W + INV_W;
    localparam int X_W = 27;
    localparam int P_W = X_W + 10;

    logic signed [TEMP_W-1:0] pk;
    logic signed [TEMP_W-1:0] t;
    logic                     is_zero;
    logic                     blue_next;
    logic                     red_next;
    logic [F_W-1:0]           f_next;
    logic [F_W-1:0]           f_reg;
    logic                     blue_reg;
    logic                     red_reg;
    logic [X_W-1:0]           x;
    logic [P_W-1:0]           prod;
    logic [COLOR_W-1:0]       comp;
    logic                     f_over;

    always_comb
    begin
        pk        = $signed({1'b0, peak_temp});
        t         = (temp > pk) ? pk : temp;
        is_zero   = (t == '0);
        blue_next = is_zero || t[TEMP_W-1];
        red_next  = !is_zero && (t == pk);
        f_next    = {{INV_W{1'b0}}, t[PEAK_W-1:0]} * {{PEAK_W{1'b0}}, inv_peak};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            f_reg    <= f_next;
            blue_reg <= blue_next;
            red_reg  <= red_next;
        end
    end

    // Each segment scales a distance of at most a quarter by 1020.
    always_comb
    begin
        f_over = |f_reg[F_W-1:28];
        unique case (f_reg[27:26])
            2'd0:    x = f_reg[X_W-1:0];
            2'd1:    x = X_W'(28'h8000000 - f_reg[27:0]);
            2'd2:    x = X_W'(f_reg[27:0] - 28'h8000000);
            default: x = X_W'(29'h10000000 - {1'b0, f_reg[27:0]});
        endcase
        prod = {x, 10'b0} - {8'b0, x, 2'b0};
        comp = prod[35:28];
    end

    always_comb
    begin
        red   = '0;
        green = '0;
        blue  = '0;
        if (blue_reg)
        begin
            blue = COLOR_FULL;
        end
        else if (red_reg || f_over)
        begin
            red = COLOR_FULL;
        end
        else
        begin
            unique case (f_reg[27:26])
                2'd0:
                begin
                    green = comp;
                    blue  = COLOR_FULL;
                end
                2'd1:
                begin
                    green = COLOR_FULL;
                    blue  = comp;
                end
                2'd2:
                begin
                    red   = comp;
                    green = COLOR_FULL;
                end
                default:
                begin
                    red   = COLOR_FULL;
                    green = comp;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/heat_stencil_cell_with_colormap_top.sv =====
// Channel   Direction  Transfer contents
// cells     sink       one grid cell with its four neighbors and source flags
// pixels    source     next temperature and RGB color of the cell
// cfg       sink       register index and write data, always ready
//
// One cell is taken per clock unless an output stall lowers cells.ready.
// The pipeline is an input register, a multiplier register and a result register.
// A stall at the output fills empty stages first and then lowers cells.ready.
// Reset clears all valid flags and loads the register defaults.
`include "heat_stencil_cell_with_colormap_top_defines.svh"

module heat_stencil_cell_with_colormap_top import hscc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hscc_cell_if.sink   cells,
    hscc_pix_if.source  pixels,
    hscc_cfg_if.sink    cfg
);

    cfg_t                     regs;
    cell_t                    cell_reg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    pix_t                     pix_reg;
    pix_t                     pix_next;
    logic                     accept;
    logic                     s2_load;
    logic                     out_load;
    logic signed [TEMP_W-1:0] eff_centre;

    hscc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign out_load     = s2_valid_reg && (!out_valid_reg || pixels.ready);
    assign s2_load      = s1_valid_reg && (!s2_valid_reg || out_load);
    assign cells.ready  = !s1_valid_reg || s2_load;
    assign accept       = cells.valid && cells.ready;
    assign pixels.valid = out_valid_reg;
    assign pixels.data  = pix_reg;

    assign eff_centre = (cell_reg.source_present && !cell_reg.on_border) ?
                        cell_reg.source_value : cell_reg.centre;

    hscc_stencil u_stencil (
        .clk       (clk),
        .load      (s2_load),
        .centre    (eff_centre),
        .north     (cell_reg.north),
        .south     (cell_reg.south),
        .east      (cell_reg.east),
        .west      (cell_reg.west),
        .on_border (cell_reg.on_border),
        .coeff_x   (regs.coeff_x),
        .coeff_y   (regs.coeff_y),
        .new_temp  (pix_next.new_temp)
    );

    hscc_colormap u_colormap (
        .clk       (clk),
        .load      (s2_load),
        .temp      (eff_centre),
        .peak_temp (regs.peak_temp),
        .inv_peak  (regs.inv_peak),
        .red       (pix_next.red),
        .green     (pix_next.green),
        .blue      (pix_next.blue)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg <= cells.data;
        end
        if (out_load)
        begin
            pix_reg <= pix_next;
        end
    end

    `HSCC_ASSERT_IMPL(a_full_stall_blocks_input, clk, rst_n, s1_valid_reg && s2_valid_reg && out_valid_reg && !pixels.ready, !cells.ready, "input taken while every stage is stalled")
    `HSCC_ASSERT_IMPL(a_red_blue_exclusive, clk, rst_n, pixels.valid, pixels.data.red == '0 || pixels.data.blue == '0, "red and blue both lit")
    `HSCC_ASSERT_IMPL(a_one_channel_full, clk, rst_n, pixels.valid, pixels.data.red == COLOR_FULL || pixels.data.green == COLOR_FULL || pixels.data.blue == COLOR_FULL, "no color channel at full scale")

endmodule
